FILE: hw/rtl/cas_pkg.sv
`timescale 1ns / 1ps

package cas_pkg;

    // register file geometry
    localparam int REG_COUNT = 16;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int DATA_W    = 32;

    // condition codes
    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_CS = 4'd2;
    localparam logic [3:0] COND_CC = 4'd3;
    localparam logic [3:0] COND_MI = 4'd4;
    localparam logic [3:0] COND_PL = 4'd5;
    localparam logic [3:0] COND_VS = 4'd6;
    localparam logic [3:0] COND_VC = 4'd7;
    localparam logic [3:0] COND_HI = 4'd8;
    localparam logic [3:0] COND_LS = 4'd9;
    localparam logic [3:0] COND_GE = 4'd10;
    localparam logic [3:0] COND_LT = 4'd11;
    localparam logic [3:0] COND_GT = 4'd12;
    localparam logic [3:0] COND_LE = 4'd13;
    localparam logic [3:0] COND_AL = 4'd14;

    // alu opcodes
    localparam logic [3:0] ALU_AND = 4'd0;
    localparam logic [3:0] ALU_EOR = 4'd1;
    localparam logic [3:0] ALU_SUB = 4'd2;
    localparam logic [3:0] ALU_RSB = 4'd3;
    localparam logic [3:0] ALU_ADD = 4'd4;
    localparam logic [3:0] ALU_TST = 4'd8;
    localparam logic [3:0] ALU_TEQ = 4'd9;
    localparam logic [3:0] ALU_CMP = 4'd10;
    localparam logic [3:0] ALU_ORR = 4'd12;
    localparam logic [3:0] ALU_MOV = 4'd13;

    typedef enum logic [1:0] {
        OP_EXEC = 2'd0,
        OP_LOAD = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift;

    typedef struct packed {
        t_op                op;
        logic [3:0]         cond;
        logic [3:0]         alu_opcode;
        logic               imm_select;
        logic               set_flags;
        logic [REG_AW-1:0]  first_reg;
        logic [REG_AW-1:0]  dest_reg;
        logic [11:0]        operand_two;
        logic [DATA_W-1:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0]  result_value;
        logic [REG_AW-1:0]  result_index;
        logic               reg_written;
        logic               cond_passed;
        logic               flag_n;
        logic               flag_z;
        logic               flag_c;
        logic               flag_v;
    } t_out_item;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    // execute result: output item, write-back and next flags
    typedef struct packed {
        t_out_item          item;
        logic               we;
        logic [REG_AW-1:0]  waddr;
        logic [DATA_W-1:0]  wdata;
        t_flags             flags;
    } t_exec;

endpackage

FILE: hw/rtl/cas_if.sv
`timescale 1ns / 1ps

// input channel
interface cas_in_if;
    import cas_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface cas_out_if;
    import cas_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cond_alu_shifter_execute_top.sv
// the input item and its register reads are registered in the execute stage, and
//   the result is registered in the output register before it is offered
// throughput: one item per cycle while the output is not stalled, set by the
//   read-execute-write loop through the register file memories (write forwarded to reads)
// reset: synchronous active-low clears the flags, the pipeline valids and the
//   register entry valid bits, so every register reads zero until written
`timescale 1ns / 1ps

module cond_alu_shifter_execute_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cas_in_if.sink    i_in,
    cas_out_if.source o_out
);
    import cas_pkg::*;

    logic              r_s1_valid;
    t_in_item          r_s1_item;
    logic              r_out_valid;
    t_out_item         r_out_item;
    t_flags            r_flags;
    logic              s1_go;
    logic              in_fire;
    logic [DATA_W-1:0] rn_val;
    logic [DATA_W-1:0] rm_val;
    logic [DATA_W-1:0] rs_val;
    logic [DATA_W-1:0] rm_val_b;
    logic              wb_we;
    t_exec             exec;

    // pipeline handshake
    assign s1_go       = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_go;
    assign in_fire     = i_in.valid && i_in.ready;
    assign wb_we       = s1_go && exec.we;

    // register file, bank a serves rn and rm, bank b serves rs
    cas_regfile u_bank_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (wb_we),
        .i_waddr   (exec.waddr),
        .i_wdata   (exec.wdata),
        .i_re      (in_fire),
        .i_raddr_a (i_in.data.first_reg),
        .i_raddr_b (i_in.data.operand_two[3:0]),
        .o_rdata_a (rn_val),
        .o_rdata_b (rm_val)
    );

    cas_regfile u_bank_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (wb_we),
        .i_waddr   (exec.waddr),
        .i_wdata   (exec.wdata),
        .i_re      (in_fire),
        .i_raddr_a (i_in.data.operand_two[11:8]),
        .i_raddr_b (i_in.data.operand_two[3:0]),
        .o_rdata_a (rs_val),
        .o_rdata_b (rm_val_b)
    );

    // execute stage logic
    cas_exec u_exec (
        .i_item   (r_s1_item),
        .i_rn_val (rn_val),
        .i_rm_val (rm_val),
        .i_rs_val (rs_val),
        .i_flags  (r_flags),
        .o_exec   (exec)
    );

    // execute stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= i_in.data;
        end
    end

    // status flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (s1_go) begin
            r_flags <= exec.flags;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_item <= exec.item;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    // both banks hold the same contents
    a_bank_coherent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (rm_val == rm_val_b))
        else $error("register banks disagree on rm");

    // overflow flag is never set
    a_v_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !o_out.data.flag_v)
        else $error("overflow flag changed");

    // a failed condition never writes back
    a_no_write_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && (r_s1_item.op == OP_EXEC) && !exec.item.cond_passed) |-> !wb_we)
        else $error("write-back on failed condition");

    // flags only move when an item completes
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(s1_go) |-> $stable(r_flags))
        else $error("flags changed without a completed item");

endmodule

FILE: hw/rtl/cas_regfile.sv
`timescale 1ns / 1ps

module cas_regfile (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [cas_pkg::REG_AW-1:0]  i_waddr,
    input  logic [cas_pkg::DATA_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [cas_pkg::REG_AW-1:0]  i_raddr_a,
    input  logic [cas_pkg::REG_AW-1:0]  i_raddr_b,
    output logic [cas_pkg::DATA_W-1:0]  o_rdata_a,
    output logic [cas_pkg::DATA_W-1:0]  o_rdata_b
);
    import cas_pkg::*;

    logic [DATA_W-1:0]    r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;
    logic [DATA_W-1:0]    r_rdata_a;
    logic [DATA_W-1:0]    r_rdata_b;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // entry valid bits, unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // registered reads, a write in the same cycle is forwarded
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr_a)) begin
                r_rdata_a <= i_wdata;
            end else if (r_valid[i_raddr_a]) begin
                r_rdata_a <= r_mem[i_raddr_a];
            end else begin
                r_rdata_a <= '0;
            end
            if (i_we && (i_waddr == i_raddr_b)) begin
                r_rdata_b <= i_wdata;
            end else if (r_valid[i_raddr_b]) begin
                r_rdata_b <= r_mem[i_raddr_b];
            end else begin
                r_rdata_b <= '0;
            end
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: hw/rtl/cas_exec.sv
`timescale 1ns / 1ps

module cas_exec (
    input  cas_pkg::t_in_item           i_item,
    input  logic [cas_pkg::DATA_W-1:0]  i_rn_val,
    input  logic [cas_pkg::DATA_W-1:0]  i_rm_val,
    input  logic [cas_pkg::DATA_W-1:0]  i_rs_val,
    input  cas_pkg::t_flags             i_flags,
    output cas_pkg::t_exec              o_exec
);
    import cas_pkg::*;

    logic              cond_ok;
    t_shift            kind;
    logic              by_reg;
    logic [7:0]        amt8;
    logic [4:0]        amt_lo;
    logic [32:0]       lsl_ext;
    logic [32:0]       lsr_ext;
    logic [32:0]       asr_ext;
    logic [63:0]       ror_w;
    logic [31:0]       ror_val;
    logic [31:0]       sign_w;
    logic [63:0]       imm_w;
    logic [31:0]       sh_val;
    logic              sh_c;
    logic [31:0]       op_b;
    logic              op_c;
    logic [31:0]       add_x;
    logic [31:0]       add_y;
    logic              add_ci;
    logic [32:0]       sum;
    logic [31:0]       alu_res;
    logic              alu_c;
    logic              alu_ok;
    logic              alu_wr;

    // condition check against current flags
    always_comb begin
        case (i_item.cond)
            COND_EQ: cond_ok = i_flags.z;
            COND_NE: cond_ok = !i_flags.z;
            COND_CS: cond_ok = i_flags.c;
            COND_CC: cond_ok = !i_flags.c;
            COND_MI: cond_ok = i_flags.n;
            COND_PL: cond_ok = !i_flags.n;
            COND_VS: cond_ok = i_flags.v;
            COND_VC: cond_ok = !i_flags.v;
            COND_HI: cond_ok = i_flags.c && !i_flags.z;
            COND_LS: cond_ok = !i_flags.c || i_flags.z;
            COND_GE: cond_ok = (i_flags.n == i_flags.v);
            COND_LT: cond_ok = (i_flags.n != i_flags.v);
            COND_GT: cond_ok = !i_flags.z && (i_flags.n == i_flags.v);
            COND_LE: cond_ok = i_flags.z || (i_flags.n != i_flags.v);
            COND_AL: cond_ok = 1'b1;
            default: cond_ok = 1'b0;
        endcase
    end

    // barrel shifter candidates for amounts 1 to 31
    assign kind    = t_shift'(i_item.operand_two[6:5]);
    assign by_reg  = i_item.operand_two[4];
    assign amt8    = by_reg ? i_rs_val[7:0] : {3'b000, i_item.operand_two[11:7]};
    assign amt_lo  = amt8[4:0];
    assign lsl_ext = {1'b0, i_rm_val} << amt_lo;
    assign lsr_ext = {i_rm_val, 1'b0} >> amt_lo;
    assign asr_ext = 33'($signed({i_rm_val, 1'b0}) >>> amt_lo);
    assign ror_w   = {i_rm_val, i_rm_val} >> amt_lo;
    assign ror_val = ror_w[31:0];
    assign sign_w  = {32{i_rm_val[31]}};

    // shifter result and carry, including the zero and large amount cases
    always_comb begin
        sh_val = i_rm_val;
        sh_c   = i_flags.c;
        if (!by_reg && (amt_lo == 5'd0)) begin
            case (kind)
                SH_LSL: begin
                    sh_val = i_rm_val;
                    sh_c   = i_flags.c;
                end
                SH_LSR: begin
                    sh_val = '0;
                    sh_c   = i_rm_val[31];
                end
                SH_ASR: begin
                    sh_val = sign_w;
                    sh_c   = i_rm_val[31];
                end
                SH_ROR: begin
                    sh_val = {i_flags.c, i_rm_val[31:1]};
                    sh_c   = i_rm_val[0];
                end
                default: ;
            endcase
        end else if (amt8 == 8'd0) begin
            sh_val = i_rm_val;
            sh_c   = i_flags.c;
        end else if (amt8[7:5] == 3'd0) begin
            case (kind)
                SH_LSL: begin
                    sh_val = lsl_ext[31:0];
                    sh_c   = lsl_ext[32];
                end
                SH_LSR: begin
                    sh_val = lsr_ext[32:1];
                    sh_c   = lsr_ext[0];
                end
                SH_ASR: begin
                    sh_val = asr_ext[32:1];
                    sh_c   = asr_ext[0];
                end
                SH_ROR: begin
                    sh_val = ror_val;
                    sh_c   = ror_val[31];
                end
                default: ;
            endcase
        end else begin
            case (kind)
                SH_LSL: begin
                    sh_val = '0;
                    sh_c   = (amt8 == 8'd32) && i_rm_val[0];
                end
                SH_LSR: begin
                    sh_val = '0;
                    sh_c   = (amt8 == 8'd32) && i_rm_val[31];
                end
                SH_ASR: begin
                    sh_val = sign_w;
                    sh_c   = i_rm_val[31];
                end
                SH_ROR: begin
                    if (amt_lo == 5'd0) begin
                        sh_val = i_rm_val;
                        sh_c   = i_rm_val[31];
                    end else begin
                        sh_val = ror_val;
                        sh_c   = ror_val[31];
                    end
                end
                default: ;
            endcase
        end
    end

    // rotated immediate, carry zero
    assign imm_w = {24'd0, i_item.operand_two[7:0], 24'd0, i_item.operand_two[7:0]}
                   >> {i_item.operand_two[11:8], 1'b0};
    assign op_b  = i_item.imm_select ? imm_w[31:0] : sh_val;
    assign op_c  = i_item.imm_select ? 1'b0 : sh_c;

    // shared adder operands
    always_comb begin
        case (i_item.alu_opcode)
            ALU_SUB, ALU_CMP: begin
                add_x  = i_rn_val;
                add_y  = ~op_b;
                add_ci = 1'b1;
            end
            ALU_RSB: begin
                add_x  = op_b;
                add_y  = ~i_rn_val;
                add_ci = 1'b1;
            end
            default: begin
                add_x  = i_rn_val;
                add_y  = op_b;
                add_ci = 1'b0;
            end
        endcase
    end

    assign sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_ci};

    // alu operation
    always_comb begin
        alu_res = '0;
        alu_c   = op_c;
        alu_ok  = 1'b1;
        alu_wr  = 1'b1;
        case (i_item.alu_opcode)
            ALU_AND: alu_res = i_rn_val & op_b;
            ALU_EOR: alu_res = i_rn_val ^ op_b;
            ALU_SUB, ALU_RSB, ALU_ADD: begin
                alu_res = sum[31:0];
                alu_c   = sum[32];
            end
            ALU_TST: begin
                alu_res = i_rn_val & op_b;
                alu_wr  = 1'b0;
            end
            ALU_TEQ: begin
                alu_res = i_rn_val ^ op_b;
                alu_wr  = 1'b0;
            end
            ALU_CMP: begin
                alu_res = sum[31:0];
                alu_c   = sum[32];
                alu_wr  = 1'b0;
            end
            ALU_ORR: alu_res = i_rn_val | op_b;
            ALU_MOV: alu_res = op_b;
            default: begin
                alu_ok = 1'b0;
                alu_wr = 1'b0;
            end
        endcase
    end

    // result item, write-back and flags per operation
    always_comb begin
        o_exec                   = '0;
        o_exec.waddr             = i_item.dest_reg;
        o_exec.wdata             = alu_res;
        o_exec.flags             = i_flags;
        case (i_item.op)
            OP_LOAD: begin
                o_exec.we                = 1'b1;
                o_exec.wdata             = i_item.write_data;
                o_exec.item.result_value = i_item.write_data;
                o_exec.item.result_index = i_item.dest_reg;
                o_exec.item.reg_written  = 1'b1;
            end
            OP_READ: begin
                o_exec.item.result_value = i_rn_val;
                o_exec.item.result_index = i_item.first_reg;
            end
            OP_EXEC: begin
                o_exec.item.result_index = i_item.dest_reg;
                o_exec.item.cond_passed  = cond_ok;
                if (cond_ok && alu_ok) begin
                    o_exec.item.result_value = alu_res;
                    o_exec.item.reg_written  = alu_wr;
                    o_exec.we                = alu_wr;
                    if (i_item.set_flags) begin
                        o_exec.flags.n = alu_res[31];
                        o_exec.flags.z = (alu_res == 32'd0);
                        o_exec.flags.c = alu_c;
                    end
                end
            end
            default: ;
        endcase
        o_exec.item.flag_n = o_exec.flags.n;
        o_exec.item.flag_z = o_exec.flags.z;
        o_exec.item.flag_c = o_exec.flags.c;
        o_exec.item.flag_v = o_exec.flags.v;
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import cas_pkg::*;

    localparam int         CYCLE_LIMIT = 200_000;
    localparam int         DRAIN_WAIT  = 8;
    localparam logic [3:0] COND_NV     = 4'd15;
    localparam logic [3:0] ALU_UNDEF   = 4'd15;

    logic i_clk;
    logic i_rst_n;

    cas_in_if  in_if ();
    cas_out_if out_if ();

    cond_alu_shifter_execute_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // clock: 2 ns period
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // shadow copy of the architectural state
    logic [DATA_W-1:0] shadow_regs [REG_COUNT];
    t_flags            shadow_flags;

    t_out_item pending_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int cycle_count   = 0;
    int n_items       = 0;
    int n_executed    = 0;
    int n_skipped     = 0;
    int n_loads       = 0;
    int n_reads       = 0;

    logic [3:0]        legal_opcodes [10] = '{ALU_AND, ALU_EOR, ALU_SUB, ALU_RSB, ALU_ADD,
                                              ALU_TST, ALU_TEQ, ALU_CMP, ALU_ORR, ALU_MOV};
    logic [DATA_W-1:0] edge_values [4]    = '{32'h0000_0000, 32'hFFFF_FFFF,
                                              32'h8000_0000, 32'h7FFF_FFFF};

    // condition check against the shadow flags
    function automatic logic cond_holds(input logic [3:0] c);
        case (c)
            COND_EQ: return shadow_flags.z;
            COND_NE: return !shadow_flags.z;
            COND_CS: return shadow_flags.c;
            COND_CC: return !shadow_flags.c;
            COND_MI: return shadow_flags.n;
            COND_PL: return !shadow_flags.n;
            COND_VS: return shadow_flags.v;
            COND_VC: return !shadow_flags.v;
            COND_HI: return shadow_flags.c && !shadow_flags.z;
            COND_LS: return !shadow_flags.c || shadow_flags.z;
            COND_GE: return shadow_flags.n == shadow_flags.v;
            COND_LT: return shadow_flags.n != shadow_flags.v;
            COND_GT: return !shadow_flags.z && (shadow_flags.n == shadow_flags.v);
            COND_LE: return shadow_flags.z || (shadow_flags.n != shadow_flags.v);
            COND_AL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // barrel shifter, returns {carry, value}
    function automatic logic [32:0] barrel_shift(input logic [31:0] v, input t_shift kind,
                                                 input logic [7:0] amt, input logic by_reg);
        logic        cin;
        logic [31:0] fill;
        logic [4:0]  r;
        cin  = shadow_flags.c;
        fill = {32{v[31]}};
        r    = amt[4:0];
        // immediate amount zero has its own meanings
        if (!by_reg && amt == 8'd0) begin
            case (kind)
                SH_LSL:  return {cin, v};
                SH_LSR:  return {v[31], 32'h0};
                SH_ASR:  return {v[31], fill};
                default: return {v[0], cin, v[31:1]};
            endcase
        end
        if (amt == 8'd0) return {cin, v};
        case (kind)
            SH_LSL: begin
                if (amt < 8'd32) return {v[32 - amt], v << amt};
                return {(amt == 8'd32) ? v[0] : 1'b0, 32'h0};
            end
            SH_LSR: begin
                if (amt < 8'd32) return {v[amt - 1], v >> amt};
                return {(amt == 8'd32) ? v[31] : 1'b0, 32'h0};
            end
            SH_ASR: begin
                if (amt < 8'd32) return {v[amt - 1], $signed(v) >>> amt};
                return {v[31], fill};
            end
            default: begin
                if (r == 5'd0) return {v[31], v};
                return {v[r - 1], (v >> r) | (v << (32 - r))};
            end
        endcase
    endfunction

    // expected result of one item; updates the shadow state
    function automatic t_out_item predict_execute(input t_in_item it);
        t_out_item   res;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm32;
        logic [4:0]  rot;
        logic [32:0] sh;
        logic        carry;
        logic        legal;
        logic        writes;
        res = '0;
        case (it.op)
            OP_LOAD: begin
                shadow_regs[it.dest_reg] = it.write_data;
                res.result_value = it.write_data;
                res.result_index = it.dest_reg;
                res.reg_written  = 1'b1;
            end
            OP_READ: begin
                res.result_value = shadow_regs[it.first_reg];
                res.result_index = it.first_reg;
            end
            OP_EXEC: begin
                res.result_index = it.dest_reg;
                if (cond_holds(it.cond)) begin
                    res.cond_passed = 1'b1;
                    a = shadow_regs[it.first_reg];
                    if (it.imm_select) begin
                        imm32 = {24'h0, it.operand_two[7:0]};
                        rot   = {it.operand_two[11:8], 1'b0};
                        b     = (imm32 >> rot) | (imm32 << (32 - rot));
                        sh    = {1'b0, b};
                    end else if (it.operand_two[4]) begin
                        sh = barrel_shift(shadow_regs[it.operand_two[3:0]],
                                          t_shift'(it.operand_two[6:5]),
                                          shadow_regs[it.operand_two[11:8]][7:0], 1'b1);
                    end else begin
                        sh = barrel_shift(shadow_regs[it.operand_two[3:0]],
                                          t_shift'(it.operand_two[6:5]),
                                          {3'b0, it.operand_two[11:7]}, 1'b0);
                    end
                    b      = sh[31:0];
                    carry  = sh[32];
                    legal  = 1'b1;
                    writes = 1'b1;
                    case (it.alu_opcode)
                        ALU_AND: res.result_value = a & b;
                        ALU_EOR: res.result_value = a ^ b;
                        ALU_SUB: begin
                            res.result_value = a - b;
                            carry = (a >= b);
                        end
                        ALU_RSB: begin
                            res.result_value = b - a;
                            carry = (b >= a);
                        end
                        ALU_ADD: {carry, res.result_value} = {1'b0, a} + {1'b0, b};
                        ALU_TST: begin
                            res.result_value = a & b;
                            writes = 1'b0;
                        end
                        ALU_TEQ: begin
                            res.result_value = a ^ b;
                            writes = 1'b0;
                        end
                        ALU_CMP: begin
                            res.result_value = a - b;
                            carry  = (a >= b);
                            writes = 1'b0;
                        end
                        ALU_ORR: res.result_value = a | b;
                        ALU_MOV: res.result_value = b;
                        default: legal = 1'b0;
                    endcase
                    if (legal) begin
                        if (writes) begin
                            shadow_regs[it.dest_reg] = res.result_value;
                            res.reg_written = 1'b1;
                        end
                        if (it.set_flags) begin
                            shadow_flags.n = res.result_value[31];
                            shadow_flags.z = (res.result_value == 32'h0);
                            shadow_flags.c = carry;
                        end
                    end else begin
                        res.result_value = '0;
                    end
                end
            end
            default: ;
        endcase
        res.flag_n = shadow_flags.n;
        res.flag_z = shadow_flags.z;
        res.flag_c = shadow_flags.c;
        res.flag_v = shadow_flags.v;
        return res;
    endfunction

    // item builders
    function automatic t_in_item make_exec(input logic [3:0] cond, input logic [3:0] opc,
                                           input logic imm, input logic setf,
                                           input logic [3:0] rn, input logic [3:0] rd,
                                           input logic [11:0] o2);
        t_in_item it;
        it             = '0;
        it.op          = OP_EXEC;
        it.cond        = cond;
        it.alu_opcode  = opc;
        it.imm_select  = imm;
        it.set_flags   = setf;
        it.first_reg   = rn;
        it.dest_reg    = rd;
        it.operand_two = o2;
        return it;
    endfunction

    function automatic t_in_item make_load(input logic [3:0] rd, input logic [31:0] d);
        t_in_item it;
        it            = '0;
        it.op         = OP_LOAD;
        it.dest_reg   = rd;
        it.write_data = d;
        return it;
    endfunction

    function automatic t_in_item make_read(input logic [3:0] rn);
        t_in_item it;
        it           = '0;
        it.op        = OP_READ;
        it.first_reg = rn;
        return it;
    endfunction

    // operand two encodings
    function automatic logic [11:0] imm_o2(input logic [3:0] rot, input logic [7:0] val);
        return {rot, val};
    endfunction

    function automatic logic [11:0] shift_imm_o2(input logic [4:0] amt, input t_shift kind,
                                                 input logic [3:0] rm);
        return {amt, kind, 1'b0, rm};
    endfunction

    function automatic logic [11:0] shift_reg_o2(input logic [3:0] rs, input t_shift kind,
                                                 input logic [3:0] rm);
        return {rs, 1'b0, kind, 1'b1, rm};
    endfunction

    // one transfer on the input channel, starting and ending at a falling edge
    task automatic send_item(input t_in_item it);
        t_out_item want;
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        want = predict_execute(it);
        pending_results.push_back(want);
        n_items++;
        if (it.op == OP_LOAD) n_loads++;
        if (it.op == OP_READ) n_reads++;
        if (it.op == OP_EXEC && want.cond_passed) n_executed++;
        if (it.op == OP_EXEC && !want.cond_passed) n_skipped++;
        @(negedge i_clk);
    endtask

    // hold off the input until every expected result is back
    task automatic wait_results_drained();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_register_access();
        send_item(make_read(4'd15));
        send_item(make_load(4'd1, 32'hFFFF_FFFF));
        send_item(make_load(4'd2, 32'h8000_0001));
        send_item(make_load(4'd3, 32'h0000_0020));
        send_item(make_load(4'd4, 32'h0000_0121));
        send_item(make_load(4'd5, 32'h0000_0040));
        send_item(make_load(4'd6, 32'h0000_0100));
        send_item(make_read(4'd2));
    endtask

    task automatic test_alu_ops();
        // add carry out, subtract borrow, reverse subtract with rotated immediate
        send_item(make_exec(COND_AL, ALU_ADD, 1'b1, 1'b1, 4'd1, 4'd7, imm_o2(4'd15, 8'h01)));
        send_item(make_exec(COND_AL, ALU_SUB, 1'b1, 1'b1, 4'd0, 4'd8, imm_o2(4'd0, 8'h01)));
        send_item(make_exec(COND_AL, ALU_RSB, 1'b1, 1'b1, 4'd2, 4'd9, imm_o2(4'd4, 8'hFF)));
        // immediate shift amount zero for each kind, one with destination equal to source
        send_item(make_exec(COND_AL, ALU_AND, 1'b0, 1'b1, 4'd1, 4'd10,
                            shift_imm_o2(5'd0, SH_LSL, 4'd2)));
        send_item(make_exec(COND_AL, ALU_EOR, 1'b0, 1'b1, 4'd1, 4'd1,
                            shift_imm_o2(5'd0, SH_LSR, 4'd2)));
        send_item(make_exec(COND_AL, ALU_ORR, 1'b0, 1'b1, 4'd0, 4'd12,
                            shift_imm_o2(5'd0, SH_ASR, 4'd2)));
        send_item(make_exec(COND_AL, ALU_MOV, 1'b0, 1'b1, 4'd0, 4'd13,
                            shift_imm_o2(5'd0, SH_ROR, 4'd2)));
    endtask

    task automatic test_register_shift_corners();
        send_item(make_exec(COND_AL, ALU_MOV, 1'b0, 1'b1, 4'd0, 4'd14,
                            shift_reg_o2(4'd3, SH_LSL, 4'd2)));
        send_item(make_exec(COND_AL, ALU_MOV, 1'b0, 1'b1, 4'd0, 4'd14,
                            shift_reg_o2(4'd4, SH_LSR, 4'd2)));
        send_item(make_exec(COND_AL, ALU_MOV, 1'b0, 1'b1, 4'd0, 4'd14,
                            shift_reg_o2(4'd3, SH_ASR, 4'd2)));
        send_item(make_exec(COND_AL, ALU_MOV, 1'b0, 1'b1, 4'd0, 4'd14,
                            shift_reg_o2(4'd5, SH_ROR, 4'd2)));
        send_item(make_exec(COND_AL, ALU_MOV, 1'b0, 1'b1, 4'd0, 4'd15,
                            shift_reg_o2(4'd6, SH_LSL, 4'd2)));
    endtask

    task automatic test_compare_ops();
        send_item(make_exec(COND_AL, ALU_TST, 1'b0, 1'b1, 4'd1, 4'd3,
                            shift_imm_o2(5'd1, SH_LSL, 4'd2)));
        send_item(make_exec(COND_AL, ALU_TEQ, 1'b1, 1'b1, 4'd2, 4'd4, imm_o2(4'd1, 8'h40)));
        send_item(make_exec(COND_AL, ALU_CMP, 1'b1, 1'b1, 4'd0, 4'd5, imm_o2(4'd0, 8'h00)));
    endtask

    task automatic test_skipped_items();
        t_in_item it;
        send_item(make_exec(COND_AL, ALU_UNDEF, 1'b1, 1'b1, 4'd1, 4'd6, imm_o2(4'd0, 8'h00)));
        send_item(make_exec(COND_NV, ALU_MOV, 1'b1, 1'b1, 4'd1, 4'd6, imm_o2(4'd0, 8'h05)));
        it    = make_read(4'd1);
        it.op = OP_NOP;
        send_item(it);
    endtask

    // random traffic, mostly executable instructions over loaded registers
    task automatic test_random_traffic(input int count);
        t_in_item    it;
        int          pick;
        logic [7:0]  low;
        for (int i = 0; i < count; i++) begin
            it.op          = OP_EXEC;
            it.cond        = 4'($urandom_range(15));
            it.alu_opcode  = 4'($urandom_range(15));
            it.imm_select  = 1'($urandom_range(1));
            it.set_flags   = ($urandom_range(99) < 70);
            it.first_reg   = 4'($urandom_range(15));
            it.dest_reg    = 4'($urandom_range(15));
            it.operand_two = 12'($urandom_range(4095));
            it.write_data  = $urandom();
            pick = $urandom_range(99);
            if (pick < 15) begin
                it.op = OP_LOAD;
                case ($urandom_range(2))
                    0: low = 8'($urandom_range(40, 24));
                    1: low = 8'($urandom_range(7) * 32);
                    default: low = 8'($urandom_range(255));
                endcase
                case ($urandom_range(2))
                    0: it.write_data[7:0] = low;
                    1: it.write_data = edge_values[2'($urandom_range(3))];
                    default: ;
                endcase
            end else if (pick < 23) begin
                it.op = OP_READ;
            end else if (pick < 26) begin
                it.op = OP_NOP;
            end else begin
                if ($urandom_range(99) < 60) it.cond = COND_AL;
                if ($urandom_range(99) < 85) begin
                    it.alu_opcode = legal_opcodes[4'($urandom_range(9))];
                end
            end
            send_item(it);
        end
    endtask

    // receiver side: random back-pressure
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare one result field
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s expected 0x%0h got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: value 0x%0h", got.result_value);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_value", want.result_value, got.result_value);
                check_field("result_index", 32'(want.result_index), 32'(got.result_index));
                check_field("reg_written",  32'(want.reg_written),  32'(got.reg_written));
                check_field("cond_passed",  32'(want.cond_passed),  32'(got.cond_passed));
                check_field("flag_n",       32'(want.flag_n),       32'(got.flag_n));
                check_field("flag_z",       32'(want.flag_z),       32'(got.flag_z));
                check_field("flag_c",       32'(want.flag_c),       32'(got.flag_c));
                check_field("flag_v",       32'(want.flag_v),       32'(got.flag_v));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[cond_alu_shifter_execute_top] ERROR");
            $finish;
        end
    end

    initial begin
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        i_rst_n     <= 1'b0;
        foreach (shadow_regs[i]) shadow_regs[i] = '0;
        shadow_flags = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_register_access();
        test_alu_ops();
        test_register_shift_corners();
        test_compare_ops();
        test_skipped_items();

        send_idle_pct = 17;
        recv_idle_pct = 66;
        test_random_traffic(550);
        wait_results_drained();

        send_idle_pct = 66;
        recv_idle_pct = 17;
        test_random_traffic(550);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(550);

        // let the pipeline empty before the verdict
        wait_results_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d items: %0d executed, %0d failed condition, %0d loads, %0d reads",
                 n_items, n_executed, n_skipped, n_loads, n_reads);
        $display("directed operand and shifter corners, then random traffic under stalls");
        if (error_count == 0) begin
            $display("[cond_alu_shifter_execute_top] OK");
        end else begin
            $display("[cond_alu_shifter_execute_top] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/cas_pkg.sv
hw/rtl/cas_if.sv
hw/rtl/cas_regfile.sv
hw/rtl/cas_exec.sv
hw/rtl/cond_alu_shifter_execute_top.sv
verif/tb.sv
